### rtl/utf16_to_utf8_encoder_macros.svh
// Assertion macros shared by the encoder's modules.
`ifndef UTF16_TO_UTF8_ENCODER_MACROS_SVH
`define UTF16_TO_UTF8_ENCODER_MACROS_SVH

`ifndef SYNTH

`define U8E_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("u8e assertion failed");

`define U8E_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("u8e assertion failed");

`else

`define U8E_ASSERT_NOW(label, pre, post)

`define U8E_ASSERT_NEXT(label, pre, post)

`endif

`endif

### rtl/u8e_pkg.sv
package u8e_pkg;

  localparam int unsigned MAX_RUN_BYTES = 4;

  localparam logic [15:0] ONE_BYTE_LIMIT = 16'h0080;
  localparam logic [15:0] TWO_BYTE_LIMIT = 16'h0800;
  localparam logic [4:0]  SURROGATE_TOP  = 5'b11011;
  localparam logic [20:0] SUPPLEMENTARY_BASE = 21'h10000;

  localparam logic [2:0] TWO_BYTE_PREFIX   = 3'b110;
  localparam logic [3:0] THREE_BYTE_PREFIX = 4'b1110;
  localparam logic [4:0] FOUR_BYTE_PREFIX  = 5'b11110;
  localparam logic [1:0] CONT_PREFIX       = 2'b10;

  typedef logic [2:0] run_count_t;

  typedef struct packed {
    logic [MAX_RUN_BYTES-1:0][7:0] bytes;
    run_count_t                    count;
  } run_t;

  typedef struct packed {
    logic valid;
    run_t run;
  } push_t;

  typedef struct packed {
    logic full;
    logic empty;
    run_t head;
  } queue_status_t;

  function automatic run_t encode_pair(input logic [9:0] lead_bits,
                                       input logic [9:0] trail_bits);
    logic [20:0] cp;
    run_t        r;
    cp = SUPPLEMENTARY_BASE + {1'b0, lead_bits, trail_bits};
    r.bytes[0] = {FOUR_BYTE_PREFIX, cp[20:18]};
    r.bytes[1] = {CONT_PREFIX, cp[17:12]};
    r.bytes[2] = {CONT_PREFIX, cp[11:6]};
    r.bytes[3] = {CONT_PREFIX, cp[5:0]};
    r.count    = run_count_t'(MAX_RUN_BYTES);
    return r;
  endfunction

endpackage

### rtl/u8e_in_if.sv
interface u8e_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        string_last;

  modport source(output valid, output code_unit, output string_last, input ready);
  modport sink(input valid, input code_unit, input string_last, output ready);
endinterface

### rtl/u8e_out_if.sv
interface u8e_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;

  modport source(output valid, output out_byte, output last_of_run, input ready);
  modport sink(input valid, input out_byte, input last_of_run, output ready);
endinterface

### rtl/utf16_to_utf8_encoder.sv
// Channel  Direction  Payload                              Transfer
// in_ch    sink       code_unit[15:0], string_last         valid && ready
// out_ch   source     out_byte[7:0], last_of_run           valid && ready
//
// A code unit is classified in the cycle it is taken and its bytes enter a run queue.
// The output side sends one byte per cycle while out_ch.ready is high; a unit yields zero to four bytes.
// The input side stalls only when the run queue of QUEUE_DEPTH runs is full.
// Reset is synchronous and clears the held lead, the stop flag and the queue.
module utf16_to_utf8_encoder #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input logic       clk,
  input logic       rst_n,
  u8e_in_if.sink    in_ch,
  u8e_out_if.source out_ch
);
  import u8e_pkg::*;

  push_t         push;
  queue_status_t q_status;
  logic          pop;

  u8e_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .q_status (q_status),
    .push     (push)
  );

  u8e_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .pop    (pop),
    .status (q_status)
  );

  u8e_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_status (q_status),
    .pop      (pop),
    .out_ch   (out_ch)
  );

endmodule

### rtl/u8e_front.sv
`include "utf16_to_utf8_encoder_macros.svh"

module u8e_front (
  input  logic                   clk,
  input  logic                   rst_n,
  u8e_in_if.sink                 in_ch,
  input  u8e_pkg::queue_status_t q_status,
  output u8e_pkg::push_t         push
);
  import u8e_pkg::*;

  logic       lead_r, lead_nxt;
  logic [9:0] held_r, held_nxt;
  logic       stopped_r, stopped_nxt;
  logic       take;
  logic [15:0] u;
  logic        last;
  run_t        rec;

  assign in_ch.ready = !q_status.full;
  assign take        = in_ch.valid && in_ch.ready;
  assign u           = in_ch.code_unit;
  assign last        = in_ch.string_last;

  always_comb begin
    rec         = '0;
    lead_nxt    = lead_r;
    held_nxt    = held_r;
    stopped_nxt = stopped_r;
    if (stopped_r) begin
      if (last) begin
        stopped_nxt = 1'b0;
      end
    end else if (lead_r) begin
      rec      = encode_pair(held_r, u[9:0]);
      lead_nxt = 1'b0;
      held_nxt = '0;
    end else if (u == '0) begin
      stopped_nxt = !last;
    end else if (u < ONE_BYTE_LIMIT) begin
      rec.bytes[0] = u[7:0];
      rec.count    = run_count_t'(1);
    end else if (u < TWO_BYTE_LIMIT) begin
      rec.bytes[0] = {TWO_BYTE_PREFIX, u[10:6]};
      rec.bytes[1] = {CONT_PREFIX, u[5:0]};
      rec.count    = run_count_t'(2);
    end else if (u[15:11] == SURROGATE_TOP) begin
      if (last) begin
        rec = encode_pair(u[9:0], 10'd0);
      end else begin
        lead_nxt = 1'b1;
        held_nxt = u[9:0];
      end
    end else begin
      rec.bytes[0] = {THREE_BYTE_PREFIX, u[15:12]};
      rec.bytes[1] = {CONT_PREFIX, u[11:6]};
      rec.bytes[2] = {CONT_PREFIX, u[5:0]};
      rec.count    = run_count_t'(3);
    end
  end

  assign push.valid = take && (rec.count != '0);
  assign push.run   = rec;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lead_r    <= 1'b0;
      held_r    <= '0;
      stopped_r <= 1'b0;
    end else if (take) begin
      lead_r    <= lead_nxt;
      held_r    <= held_nxt;
      stopped_r <= stopped_nxt;
    end
  end

  `U8E_ASSERT_NOW(a_lead_not_stopped, lead_r, !stopped_r)
  `U8E_ASSERT_NEXT(a_last_clears_state, take && last, !lead_r && !stopped_r)

endmodule

### rtl/u8e_queue.sv
`include "utf16_to_utf8_encoder_macros.svh"

module u8e_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  u8e_pkg::push_t         push,
  input  logic                   pop,
  output u8e_pkg::queue_status_t status
);
  import u8e_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

  run_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign status.full  = (count_r == FULL_COUNT);
  assign status.empty = (count_r == '0);
  assign status.head  = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push.valid) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_SLOT) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_SLOT) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push.valid && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push.valid) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem[wr_ptr_r] <= push.run;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  `U8E_ASSERT_NOW(a_no_push_when_full, push.valid, !status.full)
  `U8E_ASSERT_NOW(a_no_pop_when_empty, pop, !status.empty)

endmodule

### rtl/u8e_back.sv
`include "utf16_to_utf8_encoder_macros.svh"

module u8e_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  u8e_pkg::queue_status_t q_status,
  output logic                   pop,
  u8e_out_if.source              out_ch
);
  import u8e_pkg::*;

  logic [MAX_RUN_BYTES-1:0][7:0] bytes_r, bytes_nxt;
  run_count_t                    cnt_r, cnt_nxt;
  logic                          sent;

  assign out_ch.valid       = (cnt_r != '0);
  assign out_ch.out_byte    = bytes_r[0];
  assign out_ch.last_of_run = (cnt_r == run_count_t'(1));
  assign sent               = out_ch.valid && out_ch.ready;

  assign pop = !q_status.empty && ((cnt_r == '0) || (out_ch.last_of_run && sent));

  always_comb begin
    bytes_nxt = bytes_r;
    cnt_nxt   = cnt_r;
    if (pop) begin
      bytes_nxt = q_status.head.bytes;
      cnt_nxt   = q_status.head.count;
    end else if (sent) begin
      bytes_nxt = bytes_r >> 8;
      cnt_nxt   = cnt_r - run_count_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    bytes_r <= bytes_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  `U8E_ASSERT_NOW(a_run_fits, 1'b1, cnt_r <= run_count_t'(MAX_RUN_BYTES))
  `U8E_ASSERT_NOW(a_loaded_run_nonempty, pop, q_status.head.count != '0)

endmodule
